### src/tns_pkg.sv
// tns_pkg: shared types, codes and constants of the tone/note sequencer.
// Used by every module under src except tns_ram; depends on nothing.

package tns_pkg;

	// default sizes of the effect ring and the tune store
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TUNE_DEPTH_DEF  = 64;

	// item field widths
	localparam int CMD_W   = 3;
	localparam int NOTE_W  = 16;
	localparam int IDX_W   = 6;
	localparam int LEN_W   = 7;
	localparam int ENTRY_W = 2 * NOTE_W;
	localparam int DIV_W   = 18;
	localparam int SRC_W   = 2;

	// stream and config port widths
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 24;
	localparam int CFG_IDX_W = 1;

	// result tdata bit positions
	localparam int M_BIT_STARTED = 2 + DIV_W;

	// divider: ((APB_HZ / hz) << 8) >> 10 == APB_HZ / (4 * hz) for clamped hz
	localparam int APB_HZ    = 80000000;
	localparam int HZ_MIN    = 90;
	localparam int HZ_MAX    = 6000;
	localparam int DIV_FRAC  = 8;
	localparam int DUTY_BITS = 10;
	localparam int DIVIDEND  = APB_HZ >> (DUTY_BITS - DIV_FRAC);
	localparam int DVD_W     = $clog2(DIVIDEND + 1);
	localparam int STEP_W    = $clog2(DVD_W);
	localparam int HZC_W     = $clog2(HZ_MAX + 1);
	localparam logic [DVD_W-1:0] DIVIDEND_BITS = DVD_W'(DIVIDEND);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_PUSH    = 3'd1,
		CMD_TUNE_WR = 3'd2,
		CMD_START   = 3'd3,
		CMD_STOP    = 3'd4
	} cmd_t;

	typedef enum logic [SRC_W-1:0] {
		SRC_NONE   = 2'd0,
		SRC_EFFECT = 2'd1,
		SRC_MUSIC  = 2'd2
	} src_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOUND_ENABLE = 1'b0,
		REG_PIN_READY    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_READ,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic exec;
		logic clk_add;
		logic rd_ring;
		logic rd_tune;
		logic stop_tone;
		logic note_begin;
		logic out_load;
		src_t src;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic sound_en;
		logic note_busy;
		logic ring_empty;
		logic music_avail;
		logic pin_ready;
		logic entry_hz_zero;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

### src/tns_ram.sv
// tns_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.

module tns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/tns_ctrl.sv
// tns_ctrl: sequencing state machine of the tone/note sequencer.
// Depends on tns_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.

module tns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tns_pkg::dp_stat_t stat,
	output tns_pkg::dp_cmd_t  cmd
);

	tns_pkg::state_t state_q, state_d;
	tns_pkg::src_t   src_q, src_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tns_pkg::ST_IDLE;
			src_q   <= tns_pkg::SRC_NONE;
		end else begin
			state_q <= state_d;
			src_q   <= src_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		src_d    = src_q;
		cmd      = '0;
		cmd.src  = src_q;
		s_tready = 1'b0;
		unique case (state_q)
			tns_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					src_d         = tns_pkg::SRC_NONE;
					state_d       = tns_pkg::ST_EXEC;
				end
			end
			tns_pkg::ST_EXEC: begin
				if (stat.cmd == tns_pkg::CMD_TICK) begin
					cmd.clk_add = 1'b1;
					state_d     = tns_pkg::ST_CHECK;
				end else begin
					cmd.exec = 1'b1;
					state_d  = tns_pkg::ST_DONE;
				end
			end
			tns_pkg::ST_CHECK: begin
				if (!stat.sound_en || stat.note_busy) begin
					state_d = tns_pkg::ST_DONE;
				end else if (!stat.ring_empty) begin
					cmd.rd_ring = 1'b1;
					src_d       = tns_pkg::SRC_EFFECT;
					state_d     = tns_pkg::ST_READ;
				end else if (stat.music_avail) begin
					cmd.rd_tune = 1'b1;
					src_d       = tns_pkg::SRC_MUSIC;
					state_d     = tns_pkg::ST_READ;
				end else begin
					cmd.stop_tone = 1'b1;
					state_d       = tns_pkg::ST_DONE;
				end
			end
			tns_pkg::ST_READ: begin
				// note leaves the ring/tune even when the pin is not ready
				if (stat.pin_ready) begin
					cmd.note_begin = 1'b1;
					state_d = stat.entry_hz_zero ? tns_pkg::ST_DONE : tns_pkg::ST_DIV;
				end else begin
					src_d   = tns_pkg::SRC_NONE;
					state_d = tns_pkg::ST_DONE;
				end
			end
			tns_pkg::ST_DIV: begin
				if (stat.div_done) begin
					state_d = tns_pkg::ST_DONE;
				end
			end
			tns_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = tns_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tns_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### src/tns_dp.sv
// tns_dp: datapath of the tone/note sequencer: clock, note timer, effect ring,
// tune store, bit-serial divider and result register. Depends on tns_pkg, tns_ram.

module tns_dp #(
	parameter int QUEUE_DEPTH = tns_pkg::QUEUE_DEPTH_DEF,
	parameter int TUNE_DEPTH  = tns_pkg::TUNE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tns_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [tns_pkg::CMD_W-1:0]       s_tuser,
	input  logic                            cfg_valid,
	input  logic [tns_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                            cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tns_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [tns_pkg::SRC_W-1:0]       m_tuser,
	input  tns_pkg::dp_cmd_t                cmd,
	output tns_pkg::dp_stat_t               stat
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TAW = (TUNE_DEPTH > 1) ? $clog2(TUNE_DEPTH) : 1;
	localparam int TCW = $clog2(TUNE_DEPTH + 1);
	localparam int LW  = (TCW > tns_pkg::LEN_W) ? TCW : tns_pkg::LEN_W;
	localparam int IW  = (TAW > tns_pkg::IDX_W) ? TAW : tns_pkg::IDX_W;
	localparam int NW  = tns_pkg::NOTE_W;

	// latched item
	tns_pkg::cmd_t             cmd_q;
	logic [NW-1:0]             hz_q, ms_q, el_q;
	logic [tns_pkg::IDX_W-1:0] idx_q;
	logic [tns_pkg::LEN_W-1:0] len_q;

	// state
	logic                      sound_q, pin_q;
	logic [31:0]               clock_q, note_end_q;
	logic [QAW-1:0]            head_q, tail_q;
	logic [TCW-1:0]            count_q;
	logic [TAW-1:0]            pos_q;
	logic                      music_q, tone_q, acc_q, rd_sel_q;
	logic [tns_pkg::DIV_W-1:0] divider_q;

	// divider
	logic                        div_busy_q;
	logic [tns_pkg::STEP_W-1:0]  step_q;
	logic [tns_pkg::HZC_W-1:0]   rem_q, hzc_q, rem_nx, hzc_d;
	logic [tns_pkg::DIV_W-1:0]   quot_q, quot_nx;
	logic [tns_pkg::HZC_W:0]     trial, trial_sub;
	logic                        trial_ge;

	// output register
	logic                          m_valid_q;
	logic [tns_pkg::M_TDATA_W-1:0] m_data_q;
	logic [tns_pkg::SRC_W-1:0]     m_user_q;

	logic [QAW-1:0]             head_nx, tail_nx;
	logic                       ring_push, ring_we, tune_we, idx_in;
	logic [TAW-1:0]             pos_nx;
	logic [IW-1:0]              idx_w;
	logic [LW-1:0]              len_w, len_sat;
	logic [31:0]                clk_diff;
	logic [tns_pkg::ENTRY_W-1:0] ring_rdata, tune_rdata, entry, wr_entry;
	logic [NW-1:0]              hz_e, ms_e;

	assign head_nx   = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
	assign tail_nx   = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QAW'(1);
	assign ring_push = sound_q && (tail_nx != head_q);
	assign pos_nx    = ((TCW'(pos_q) + TCW'(1)) == count_q) ? '0 : pos_q + TAW'(1);
	assign idx_w     = IW'(idx_q);
	assign idx_in    = 32'(idx_q) < 32'(TUNE_DEPTH);
	assign len_w     = LW'(len_q);
	assign len_sat   = (len_w > LW'(TUNE_DEPTH)) ? LW'(TUNE_DEPTH) : len_w;
	assign wr_entry  = {ms_q, hz_q};
	assign ring_we   = cmd.exec && (cmd_q == tns_pkg::CMD_PUSH) && ring_push;
	assign tune_we   = cmd.exec && (cmd_q == tns_pkg::CMD_TUNE_WR) && idx_in;

	assign entry = rd_sel_q ? tune_rdata : ring_rdata;
	assign hz_e  = entry[NW-1:0];
	assign ms_e  = entry[tns_pkg::ENTRY_W-1:NW];

	// signed distance from note end; note still running while negative
	assign clk_diff = clock_q - note_end_q;

	always_comb begin
		if (hz_e < NW'(tns_pkg::HZ_MIN)) begin
			hzc_d = tns_pkg::HZC_W'(tns_pkg::HZ_MIN);
		end else if (hz_e > NW'(tns_pkg::HZ_MAX)) begin
			hzc_d = tns_pkg::HZC_W'(tns_pkg::HZ_MAX);
		end else begin
			hzc_d = hz_e[tns_pkg::HZC_W-1:0];
		end
	end

	// one restoring step per cycle, MSB of the constant dividend first
	assign trial     = {rem_q, tns_pkg::DIVIDEND_BITS[step_q]};
	assign trial_sub = trial - {1'b0, hzc_q};
	assign trial_ge  = trial >= {1'b0, hzc_q};
	assign rem_nx    = trial_ge ? trial_sub[tns_pkg::HZC_W-1:0] : trial[tns_pkg::HZC_W-1:0];
	assign quot_nx   = {quot_q[tns_pkg::DIV_W-2:0], trial_ge};

	tns_ram #(.WIDTH(tns_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (tail_q),
		.wdata (wr_entry),
		.re    (cmd.rd_ring),
		.raddr (head_q),
		.rdata (ring_rdata)
	);

	tns_ram #(.WIDTH(tns_pkg::ENTRY_W), .DEPTH(TUNE_DEPTH)) u_tune (
		.clk   (clk),
		.we    (tune_we),
		.waddr (idx_w[TAW-1:0]),
		.wdata (wr_entry),
		.re    (cmd.rd_tune),
		.raddr (pos_q),
		.rdata (tune_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_q    <= 1'b0;
			pin_q      <= 1'b0;
			clock_q    <= '0;
			note_end_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			music_q    <= 1'b0;
			tone_q     <= 1'b0;
			acc_q      <= 1'b0;
			rd_sel_q   <= 1'b0;
			divider_q  <= '0;
			div_busy_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (tns_pkg::cfg_reg_t'(cfg_index))
					tns_pkg::REG_SOUND_ENABLE: begin
						sound_q <= cfg_data;
						if (!cfg_data) begin
							head_q     <= '0;
							tail_q     <= '0;
							note_end_q <= '0;
							tone_q     <= 1'b0;
						end
					end
					tns_pkg::REG_PIN_READY: begin
						pin_q <= cfg_data;
						if (cfg_data) begin
							tone_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_item) begin
				acc_q <= 1'b0;
			end
			if (cmd.exec) begin
				case (cmd_q)
					tns_pkg::CMD_PUSH: begin
						if (ring_push) begin
							tail_q <= tail_nx;
							acc_q  <= 1'b1;
						end
					end
					tns_pkg::CMD_START: begin
						count_q <= TCW'(len_sat);
						pos_q   <= '0;
						music_q <= (len_sat != '0);
					end
					tns_pkg::CMD_STOP: begin
						music_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.clk_add) begin
				clock_q <= clock_q + 32'(el_q);
			end
			if (cmd.rd_ring) begin
				head_q   <= head_nx;
				rd_sel_q <= 1'b0;
			end
			if (cmd.rd_tune) begin
				pos_q    <= pos_nx;
				rd_sel_q <= 1'b1;
			end
			if (cmd.stop_tone && (note_end_q != '0)) begin
				tone_q     <= 1'b0;
				note_end_q <= '0;
			end
			if (cmd.note_begin) begin
				note_end_q <= clock_q + 32'(ms_e);
				if (hz_e == '0) begin
					tone_q <= 1'b0;
				end else begin
					div_busy_q <= 1'b1;
				end
			end
			if (div_busy_q && (step_q == '0)) begin
				div_busy_q <= 1'b0;
				divider_q  <= quot_nx;
				tone_q     <= 1'b1;
			end
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q <= tns_pkg::cmd_t'(s_tuser);
			hz_q  <= s_tdata[NW-1:0];
			ms_q  <= s_tdata[2*NW-1:NW];
			el_q  <= s_tdata[3*NW-1:2*NW];
			idx_q <= s_tdata[3*NW+tns_pkg::IDX_W-1:3*NW];
			len_q <= s_tdata[3*NW+tns_pkg::IDX_W+tns_pkg::LEN_W-1:3*NW+tns_pkg::IDX_W];
		end
		if (cmd.note_begin) begin
			rem_q  <= '0;
			quot_q <= '0;
			hzc_q  <= hzc_d;
			step_q <= tns_pkg::STEP_W'(tns_pkg::DVD_W - 1);
		end else if (div_busy_q) begin
			rem_q  <= rem_nx;
			quot_q <= quot_nx;
			step_q <= step_q - tns_pkg::STEP_W'(1);
		end
		if (cmd.out_load) begin
			m_data_q <= {2'b00, music_q, (cmd.src != tns_pkg::SRC_NONE), divider_q, tone_q,
				acc_q};
			m_user_q <= cmd.src;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	always_comb begin
		stat               = '0;
		stat.cmd           = cmd_q;
		stat.sound_en      = sound_q;
		stat.note_busy     = (note_end_q != '0) && clk_diff[31];
		stat.ring_empty    = (head_q == tail_q);
		stat.music_avail   = music_q && (count_q != '0);
		stat.pin_ready     = pin_q;
		stat.entry_hz_zero = (hz_e == '0);
		stat.div_done      = div_busy_q && (step_q == '0);
		stat.out_free      = !m_valid_q || m_tready;
	end

endmodule

### src/tone_note_sequencer_core.sv
// tone_note_sequencer_core: top level of the tone/note sequencer.
// Depends on tns_pkg, tns_ctrl, tns_dp (which holds two tns_ram instances).

// Plays timed square-wave notes. Commands arrive one per slave-side transfer
// (tuser = command: tick, push effect, write tune slot, start, stop music) and
// each gives exactly one result transfer on the master side. A tick advances
// the millisecond clock and, while sound is enabled and the current note has
// run out, starts the next queued effect note, else the next tune note
// (looping), else silences. A command other than tick passes through the
// exec and done states; a tick passes through exec, check and done, and
// also read when it takes a note, sounding or not (a rest, or the pin not
// assigned); one that starts a sounded note also waits in the div state for
// the 25-step bit-serial divider that computes the timer divider. The result
// sits in an output register, so the next command is taken while it waits.
// The effect ring and the tune store are RAMs with no clear after reset: ring
// pointers define what is valid, and tune slots must be written before a tune
// that uses them is started. Configuration writes are always ready and are
// only to be issued while no command is in flight.

module tone_note_sequencer_core #(
	parameter int QUEUE_DEPTH = tns_pkg::QUEUE_DEPTH_DEF,
	parameter int TUNE_DEPTH  = tns_pkg::TUNE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// note_hz[15:0], note_ms[31:16], elapsed_ms[47:32], tune_index[53:48],
	// tune_length[60:54], zero fill above
	input  logic [tns_pkg::S_TDATA_W-1:0] s_tdata,
	// command
	input  logic [tns_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// accepted[0], tone_on[1], timer_divider[19:2], note_started[20],
	// music_playing[21], zero fill above
	output logic [tns_pkg::M_TDATA_W-1:0] m_tdata,
	// note_source
	output logic [tns_pkg::SRC_W-1:0]     m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data
);

	tns_pkg::dp_cmd_t  dp_cmd;
	tns_pkg::dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	tns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	tns_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TUNE_DEPTH  (TUNE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

`ifndef SYNTH
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> dp_stat.out_free)
		else $error("result loaded over an untaken result");

	a_ring_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.rd_ring |-> !dp_stat.ring_empty)
		else $error("effect ring read while empty");

	a_started_matches_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[tns_pkg::M_BIT_STARTED] == (m_tuser != tns_pkg::SRC_NONE)))
		else $error("note_started disagrees with note_source");
`endif

endmodule
